/* rtl/core/ptpc_pkg.sv */
// ----------------------------------------------------------------------------
// ptpc_pkg
// Shared types, codes and helper functions of the pan/tilt axis position
// controller.
// ----------------------------------------------------------------------------
package ptpc_pkg;

	localparam logic [9:0] FULL_SWEEP = 10'd721;

	localparam logic [7:0]        STEP_SIZE_RST    = 8'd8;
	localparam logic [4:0]        PATROL_SPEED_RST = 5'd10;
	localparam logic [4:0]        TRAVEL_SPEED_RST = 5'd16;
	localparam logic [4:0]        IDLE_SPEED_RST   = 5'd16;
	localparam logic signed [9:0] CENTER_ANGLE_RST = 10'sd0;

	typedef enum logic [2:0] {
		CMD_EVENT    = 3'd0,
		CMD_STEP_CW  = 3'd1,
		CMD_STEP_CCW = 3'd2,
		CMD_PATROL   = 3'd3,
		CMD_SAVE     = 3'd4,
		CMD_GOTO     = 3'd5,
		CMD_CAL      = 3'd6
	} cmd_e;

	typedef enum logic [1:0] {
		EV_STOP  = 2'd0,
		EV_HIT   = 2'd1,
		EV_UNHIT = 2'd2
	} event_e;

	typedef enum logic [2:0] {
		MODE_STOP = 3'd0,
		MODE_STEP = 3'd1,
		MODE_RUN  = 3'd2,
		MODE_GOTO = 3'd3,
		MODE_CAL  = 3'd4
	} mode_e;

	typedef enum logic [1:0] {
		ORD_STATUS = 2'd0,
		ORD_TURN   = 2'd1,
		ORD_SPEED  = 2'd2
	} order_e;

	typedef enum logic [2:0] {
		CFG_STEP_SIZE    = 3'd0,
		CFG_PATROL_SPEED = 3'd1,
		CFG_TRAVEL_SPEED = 3'd2,
		CFG_IDLE_SPEED   = 3'd3,
		CFG_CENTER_ANGLE = 3'd4
	} cfg_idx_e;

	typedef struct packed {
		logic [2:0] command;
		logic [1:0] event_code;
		logic [9:0] event_remaining;
	} item_t;

	typedef struct packed {
		logic [7:0]        step_size;
		logic [4:0]        patrol_speed;
		logic [4:0]        travel_speed;
		logic [4:0]        idle_speed;
		logic signed [9:0] center_angle;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         order;
		logic [9:0]         turn_angle;
		logic               turn_clockwise;
		logic [4:0]         speed_value;
		logic               accepted;
		logic [2:0]         mode_now;
		logic signed [10:0] position;
		logic               last;
	} res_t;

	typedef struct packed {
		res_t [2:0] ent;
		logic [1:0] cnt;
	} batch_t;

	typedef struct packed {
		logic               at_edge;
		logic [9:0]         angle;
		logic signed [10:0] backoff;
	} step_res_t;

	function automatic logic [9:0] turn_clamp(input logic signed [12:0] a);
		logic [9:0] r;
		if (a < 13'sd0) begin
			r = 10'd0;
		end else if (a > 13'sd1023) begin
			r = 10'd1023;
		end else begin
			r = a[9:0];
		end
		return r;
	endfunction

	function automatic res_t mk_turn(input logic signed [12:0] a, input logic cw);
		res_t r;
		r = '0;
		r.order = ORD_TURN;
		r.turn_angle = turn_clamp(a);
		r.turn_clockwise = cw;
		return r;
	endfunction

	function automatic res_t mk_speed(input logic [4:0] s);
		res_t r;
		r = '0;
		r.order = ORD_SPEED;
		r.speed_value = s;
		return r;
	endfunction

	function automatic res_t mk_status(input logic acc, input logic [2:0] mode,
			input logic signed [10:0] pos);
		res_t r;
		r = '0;
		r.order = ORD_STATUS;
		r.accepted = acc;
		r.mode_now = mode;
		r.position = pos;
		r.last = 1'b1;
		return r;
	endfunction

	// Plain step, or drive to the hard stop when the soft limit is within reach.
	function automatic step_res_t begin_step(input logic cw,
			input logic signed [10:0] cur, input logic signed [10:0] upl,
			input logic signed [10:0] lol, input logic [7:0] step);
		step_res_t        r;
		logic signed [12:0] gap;
		gap = cw ? (13'(upl) - 13'(cur)) : (13'(cur) - 13'(lol));
		r = '0;
		if (gap <= $signed({5'b0, step})) begin
			r.at_edge = 1'b1;
			r.angle = FULL_SWEEP;
			if (gap < -13'sd1024) begin
				r.backoff = -11'sd1024;
			end else if (gap > 13'sd1023) begin
				r.backoff = 11'sd1023;
			end else begin
				r.backoff = gap[10:0];
			end
		end else begin
			r.angle = {2'b0, step};
		end
		return r;
	endfunction

endpackage

/* rtl/core/ptpc_in_reg.sv */
// ----------------------------------------------------------------------------
// ptpc_in_reg
// Input register: holds one accepted word until the engine takes it.
// ----------------------------------------------------------------------------
module ptpc_in_reg
	import ptpc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  valid_s1,
	output item_t item_s1,
	input  logic  take
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

/* rtl/core/ptpc_engine.sv */
// ----------------------------------------------------------------------------
// ptpc_engine
// Axis state and the single-pass update: one item in, up to two orders and
// a status report out as one batch.
// ----------------------------------------------------------------------------
module ptpc_engine
	import ptpc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   valid_s1,
	input  item_t  item_s1,
	input  logic   buf_ready,
	output logic   take,
	output batch_t batch
);

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_STEP_STOP  = 4'd1,
		PH_EDGE_HIT   = 4'd2,
		PH_EDGE_STOP  = 4'd3,
		PH_GOTO_STOP  = 4'd4,
		PH_CAL_HIT1   = 4'd5,
		PH_CAL_UNHIT1 = 4'd6,
		PH_CAL_HIT2   = 4'd7,
		PH_CAL_UNHIT2 = 4'd8,
		PH_CAL_STOP   = 4'd9
	} phase_e;

	mode_e              mode_q, nx_mode;
	phase_e             phase_q, nx_phase;
	logic signed [10:0] cur_q, sav_q, upl_q, lol_q, boff_q;
	logic signed [10:0] nx_cur, nx_sav, nx_upl, nx_lol, nx_boff;
	logic               cw_q, nx_cw;
	logic [9:0]         cal2_q, cal3_q, nx_cal2, nx_cal3;

	logic               idle, acc;
	logic [1:0]         n_ord;
	res_t               res [3];
	step_res_t          bs;
	logic signed [12:0] move_len, span, half;

	assign take = valid_s1 && buf_ready;
	assign idle = (mode_q == MODE_STOP) && (phase_q == PH_IDLE);

	always_comb begin
		nx_mode  = mode_q;
		nx_phase = phase_q;
		nx_cur   = cur_q;
		nx_sav   = sav_q;
		nx_upl   = upl_q;
		nx_lol   = lol_q;
		nx_boff  = boff_q;
		nx_cw    = cw_q;
		nx_cal2  = cal2_q;
		nx_cal3  = cal3_q;
		acc      = 1'b0;
		n_ord    = 2'd0;
		res[0]   = '0;
		res[1]   = '0;
		res[2]   = '0;
		bs       = '0;
		move_len = '0;
		span     = '0;
		half     = '0;

		case (cmd_e'(item_s1.command))
			CMD_EVENT: begin
				acc = 1'b1;
				case (phase_q)
					PH_STEP_STOP, PH_EDGE_STOP, PH_GOTO_STOP, PH_CAL_STOP: begin
						if (item_s1.event_code != EV_STOP && item_s1.event_remaining != 10'd0) begin
							res[n_ord] = mk_turn(13'({3'b0, item_s1.event_remaining}), nx_cw);
							n_ord = n_ord + 2'd1;
						end else if (phase_q == PH_STEP_STOP || phase_q == PH_EDGE_STOP) begin
							if (phase_q == PH_STEP_STOP) begin
								nx_cur = cw_q ? 11'(cur_q + $signed({3'b0, cfg.step_size}))
									: 11'(cur_q - $signed({3'b0, cfg.step_size}));
							end
							if (mode_q == MODE_RUN) begin
								bs = begin_step(nx_cw, nx_cur, nx_upl, nx_lol, cfg.step_size);
								res[n_ord] = mk_turn(13'({3'b0, bs.angle}), nx_cw);
								n_ord = n_ord + 2'd1;
								if (bs.at_edge) begin
									nx_boff  = bs.backoff;
									nx_phase = PH_EDGE_HIT;
								end else begin
									nx_phase = PH_STEP_STOP;
								end
							end else begin
								if (mode_q != MODE_STEP) begin
									res[n_ord] = mk_speed(cfg.idle_speed);
									n_ord = n_ord + 2'd1;
								end
								nx_mode  = MODE_STOP;
								nx_phase = PH_IDLE;
							end
						end else begin
							nx_cur   = sav_q;
							nx_mode  = MODE_STOP;
							nx_phase = PH_IDLE;
							res[n_ord] = mk_speed(cfg.idle_speed);
							n_ord = n_ord + 2'd1;
						end
					end
					PH_EDGE_HIT: begin
						if (item_s1.event_code == EV_HIT) begin
							nx_cw = !cw_q;
							res[n_ord] = mk_turn(13'(boff_q) + 13'sd1, nx_cw);
							n_ord = n_ord + 2'd1;
							nx_phase = PH_EDGE_STOP;
						end
					end
					PH_CAL_HIT1: begin
						if (item_s1.event_code == EV_HIT) begin
							nx_cw = 1'b0;
							res[n_ord] = mk_turn(13'({3'b0, item_s1.event_remaining}), nx_cw);
							n_ord = n_ord + 2'd1;
							nx_phase = PH_CAL_UNHIT1;
						end
					end
					PH_CAL_UNHIT1: begin
						if (item_s1.event_code == EV_UNHIT) begin
							nx_cal2 = item_s1.event_remaining;
							res[n_ord] = mk_turn(13'({3'b0, item_s1.event_remaining}), nx_cw);
							n_ord = n_ord + 2'd1;
							nx_phase = PH_CAL_HIT2;
						end
					end
					PH_CAL_HIT2: begin
						if (item_s1.event_code == EV_HIT) begin
							nx_cal3 = item_s1.event_remaining;
							nx_cw = 1'b1;
							res[n_ord] = mk_turn(13'({3'b0, item_s1.event_remaining}), nx_cw);
							n_ord = n_ord + 2'd1;
							nx_phase = PH_CAL_UNHIT2;
						end
					end
					PH_CAL_UNHIT2: begin
						if (item_s1.event_code == EV_UNHIT) begin
							span = $signed({3'b0, cal2_q}) + $signed({3'b0, item_s1.event_remaining})
								- $signed({2'b0, cal3_q, 1'b0});
							half = (span + $signed({12'b0, span[12]})) >>> 1;
							nx_upl = half[10:0];
							nx_lol = -half[10:0];
							nx_sav = 11'(cfg.center_angle);
							nx_cur = nx_lol;
							res[n_ord] = mk_turn(13'(nx_sav) - 13'(nx_lol), nx_cw);
							n_ord = n_ord + 2'd1;
							nx_phase = PH_CAL_STOP;
						end
					end
					default: begin
					end
				endcase
			end
			CMD_STEP_CW, CMD_STEP_CCW: begin
				if (idle) begin
					acc     = 1'b1;
					nx_mode = MODE_STEP;
					nx_cw   = (item_s1.command == CMD_STEP_CW);
					bs = begin_step(nx_cw, nx_cur, nx_upl, nx_lol, cfg.step_size);
					res[n_ord] = mk_turn(13'({3'b0, bs.angle}), nx_cw);
					n_ord = n_ord + 2'd1;
					if (bs.at_edge) begin
						nx_boff  = bs.backoff;
						nx_phase = PH_EDGE_HIT;
					end else begin
						nx_phase = PH_STEP_STOP;
					end
				end
			end
			CMD_PATROL: begin
				if (mode_q == MODE_RUN) begin
					acc     = 1'b1;
					nx_mode = MODE_STOP;
				end else if (idle) begin
					acc     = 1'b1;
					nx_mode = MODE_RUN;
					res[n_ord] = mk_speed(cfg.patrol_speed);
					n_ord = n_ord + 2'd1;
					nx_cw = 1'b1;
					bs = begin_step(nx_cw, nx_cur, nx_upl, nx_lol, cfg.step_size);
					res[n_ord] = mk_turn(13'({3'b0, bs.angle}), nx_cw);
					n_ord = n_ord + 2'd1;
					if (bs.at_edge) begin
						nx_boff  = bs.backoff;
						nx_phase = PH_EDGE_HIT;
					end else begin
						nx_phase = PH_STEP_STOP;
					end
				end
			end
			CMD_SAVE: begin
				acc    = 1'b1;
				nx_sav = cur_q;
			end
			CMD_GOTO: begin
				if (idle) begin
					acc     = 1'b1;
					nx_mode = MODE_GOTO;
					res[n_ord] = mk_speed(cfg.travel_speed);
					n_ord = n_ord + 2'd1;
					move_len = 13'(sav_q) - 13'(cur_q);
					if (move_len > 13'sd0) begin
						nx_cw = 1'b1;
					end else if (move_len < 13'sd0) begin
						nx_cw    = 1'b0;
						move_len = -move_len;
					end
					res[n_ord] = mk_turn(move_len, nx_cw);
					n_ord = n_ord + 2'd1;
					nx_phase = PH_GOTO_STOP;
				end
			end
			CMD_CAL: begin
				if (idle) begin
					acc     = 1'b1;
					nx_mode = MODE_CAL;
					res[n_ord] = mk_speed(cfg.travel_speed);
					n_ord = n_ord + 2'd1;
					nx_cw = 1'b1;
					res[n_ord] = mk_turn(13'({3'b0, FULL_SWEEP}), nx_cw);
					n_ord = n_ord + 2'd1;
					nx_phase = PH_CAL_HIT1;
				end
			end
			default: begin
			end
		endcase

		res[n_ord] = mk_status(acc, nx_mode, nx_cur);
		batch.ent[0] = res[0];
		batch.ent[1] = res[1];
		batch.ent[2] = res[2];
		batch.cnt    = n_ord + 2'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_STOP;
			phase_q <= PH_IDLE;
			cur_q   <= '0;
			sav_q   <= '0;
			upl_q   <= '0;
			lol_q   <= '0;
			boff_q  <= '0;
			cw_q    <= 1'b0;
			cal2_q  <= '0;
			cal3_q  <= '0;
		end else if (take) begin
			mode_q  <= nx_mode;
			phase_q <= nx_phase;
			cur_q   <= nx_cur;
			sav_q   <= nx_sav;
			upl_q   <= nx_upl;
			lol_q   <= nx_lol;
			boff_q  <= nx_boff;
			cw_q    <= nx_cw;
			cal2_q  <= nx_cal2;
			cal3_q  <= nx_cal3;
		end
	end

	a_idle_phase_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> mode_q == MODE_STOP)
		else $error("motion mode active with no wait pending");

	a_save_copies: assert property (@(posedge clk) disable iff (!arst_n)
		take && item_s1.command == CMD_SAVE |=> sav_q == $past(cur_q))
		else $error("save did not capture the current angle");

	a_busy_refused: assert property (@(posedge clk) disable iff (!arst_n)
		take && !idle && item_s1.command == CMD_CAL |=> $stable(phase_q))
		else $error("calibrate taken while busy");

endmodule

/* rtl/core/ptpc_out_buf.sv */
// ----------------------------------------------------------------------------
// ptpc_out_buf
// Result buffer: holds one batch and sends its words one at a time.
// ----------------------------------------------------------------------------
module ptpc_out_buf
	import ptpc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load,
	input  batch_t batch,
	output logic   buf_ready,
	output logic   out_valid,
	input  logic   out_ready,
	output res_t   out_res
);

	res_t       ent_q [3];
	logic [1:0] n_q, rd_q;
	logic       valid_q, pop, at_end;

	assign out_valid = valid_q;
	assign out_res   = ent_q[rd_q];
	assign pop       = valid_q && out_ready;
	assign at_end    = (rd_q == n_q - 2'd1);
	assign buf_ready = !valid_q || (pop && at_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			n_q     <= 2'd1;
			rd_q    <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			n_q     <= batch.cnt;
			rd_q    <= 2'd0;
		end else if (pop) begin
			if (at_end) begin
				valid_q <= 1'b0;
			end else begin
				rd_q <= rd_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q[0] <= batch.ent[0];
			ent_q[1] <= batch.ent[1];
			ent_q[2] <= batch.ent[2];
		end
	end

	a_rd_in_batch: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (rd_q < n_q) && (n_q != 2'd0))
		else $error("read index past end of batch");

	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && at_end |-> out_res.last)
		else $error("final word of batch lacks last");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> buf_ready)
		else $error("batch loaded over undelivered words");

endmodule

/* rtl/core/pan_tilt_axis_position_controller_core.sv */
// ----------------------------------------------------------------------------
// pan_tilt_axis_position_controller_core
// Position controller for one pan or tilt axis: host commands and motor
// events in, turn orders, speed orders and a status report out.
//
//  channel  dir  tdata (low bit up)                           tuser    tlast
//  s_axis   in   event_code[1:0] event_remaining[11:2] pad    command  -
//  m_axis   out  turn_angle[9:0] turn_clockwise[10]           order    last
//                speed_value[15:11] accepted[16]
//                mode_now[19:17] position[30:20] pad
//  cfg      in   cfg_index selects register, cfg_wdata value   -        -
//
// An accepted word reaches the engine in the cycle after it is accepted; its
// results are registered in the result buffer when the engine takes the word,
// which it does only once the buffer is empty or its last word is leaving.
// Each input word yields one to three output words, sent one at a time.
// Reset clears the axis state and loads the register defaults. A stall on
// m_axis holds the buffer, and the input register then holds the next word.
// ----------------------------------------------------------------------------
module pan_tilt_axis_position_controller_core
	import ptpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // event_code, event_remaining
	input  logic [2:0]  s_axis_tuser,   // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // turn_angle, turn_clockwise, speed_value,
	                                    // accepted, mode_now, position
	output logic [1:0]  m_axis_tuser,   // order
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_wdata
);

	cfg_t   cfg_q;
	item_t  in_item, item_s1;
	logic   valid_s1, take, buf_ready;
	batch_t batch;
	res_t   out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_size    <= STEP_SIZE_RST;
			cfg_q.patrol_speed <= PATROL_SPEED_RST;
			cfg_q.travel_speed <= TRAVEL_SPEED_RST;
			cfg_q.idle_speed   <= IDLE_SPEED_RST;
			cfg_q.center_angle <= CENTER_ANGLE_RST;
		end else if (cfg_we) begin
			case (cfg_idx_e'(cfg_index))
				CFG_STEP_SIZE:    cfg_q.step_size    <= cfg_wdata[7:0];
				CFG_PATROL_SPEED: cfg_q.patrol_speed <= cfg_wdata[4:0];
				CFG_TRAVEL_SPEED: cfg_q.travel_speed <= cfg_wdata[4:0];
				CFG_IDLE_SPEED:   cfg_q.idle_speed   <= cfg_wdata[4:0];
				CFG_CENTER_ANGLE: cfg_q.center_angle <= $signed(cfg_wdata);
				default: begin
				end
			endcase
		end
	end

	assign in_item.command         = s_axis_tuser;
	assign in_item.event_code      = s_axis_tdata[1:0];
	assign in_item.event_remaining = s_axis_tdata[11:2];

	ptpc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take     (take)
	);

	ptpc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.buf_ready (buf_ready),
		.take      (take),
		.batch     (batch)
	);

	ptpc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.batch     (batch),
		.buf_ready (buf_ready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {1'b0, out_res.position, out_res.mode_now, out_res.accepted,
		out_res.speed_value, out_res.turn_clockwise, out_res.turn_angle};
	assign m_axis_tuser = out_res.order;
	assign m_axis_tlast = out_res.last;

endmodule
